@@ hdl/flac_pkg.sv @@
// ----------------------------------------------------------------------------
// flac_pkg
// Shared types and constants of the flag layer alpha compositor.
// ----------------------------------------------------------------------------
package flac_pkg;

    localparam int FIELD_LAYERS = 2;
    localparam int FLAG_BITS    = 32;
    localparam int APB_AW       = 4;

    localparam int          ALPHA_LSB = 24;
    localparam logic [7:0]  CH_MAX    = 8'hFF;

    localparam logic OP_COMPOSE = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    typedef enum logic [1:0] {
        REG_MASK0 = 2'd0,
        REG_MASK1 = 2'd1,
        REG_CNT0  = 2'd2,
        REG_CNT1  = 2'd3
    } flac_reg_t;

    // request token travelling down the cell chain
    typedef struct packed {
        logic        valid;
        logic        wr;
        logic [0:0]  wr_layer;
        logic [4:0]  wr_index;
        logic [31:0] wr_color;
        logic [31:0] color;
    } flac_tok_t;

    function automatic logic [31:0] blend_over(input logic [31:0] src,
                                               input logic [31:0] dst);
        logic [7:0]  a;
        logic [7:0]  inv;
        logic [7:0]  da;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] oa;
        logic [31:0] res;
        da  = dst[ALPHA_LSB +: 8];
        a   = src[ALPHA_LSB +: 8];
        inv = CH_MAX - a;
        r   = {8'd0, src[23:16]} * {8'd0, a} + {8'd0, dst[23:16]} * {8'd0, inv};
        g   = {8'd0, src[15:8]}  * {8'd0, a} + {8'd0, dst[15:8]}  * {8'd0, inv};
        b   = {8'd0, src[7:0]}   * {8'd0, a} + {8'd0, dst[7:0]}   * {8'd0, inv};
        oa  = {8'd0, da} * {8'd0, inv};
        if (da == 8'd0)
        begin
            res = src;
        end
        else if (a == 8'd0)
        begin
            res = dst;
        end
        else
        begin
            res = {a + oa[15:8], r[15:8], g[15:8], b[15:8]};
        end
        return res;
    endfunction

endpackage

@@ hdl/flac_if.sv @@
// ----------------------------------------------------------------------------
// flac_if
// Valid/ready channels of the compositor: request in, pixel out.
// ----------------------------------------------------------------------------
interface flac_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] layer0_flags;
    logic [31:0] layer1_flags;
    logic        palette_layer;
    logic [4:0]  palette_index;
    logic [31:0] palette_color;

    modport source (output valid, output operation, output layer0_flags,
                    output layer1_flags, output palette_layer, output palette_index,
                    output palette_color, input ready);
    modport sink   (input valid, input operation, input layer0_flags,
                    input layer1_flags, input palette_layer, input palette_index,
                    input palette_color, output ready);
endinterface

interface flac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_argb;

    modport source (output valid, output pixel_argb, input ready);
    modport sink   (input valid, input pixel_argb, output ready);
endinterface

@@ hdl/flac_cell.sv @@
// ----------------------------------------------------------------------------
// flac_cell
// One palette entry of the chain: holds its colour, takes palette writes that
// reach it and blends its colour over a passing pixel when its flag is set.
// ----------------------------------------------------------------------------
module flac_cell
    import flac_pkg::*;
#(
    parameter int NC       = 64,
    parameter int CELL_ID  = 0,
    parameter int LAYER_ID = 0,
    parameter int FLAG_ID  = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  flac_tok_t       tok_in,
    input  logic [NC-1:0]   en_in,
    output flac_tok_t       tok_out,
    output logic [NC-1:0]   en_out
);

    logic [31:0]    pal_reg;
    logic           valid_reg;
    flac_tok_t      tok_reg;
    logic [NC-1:0]  en_reg;
    flac_tok_t      tok_next;
    logic           hit;

    assign hit = tok_in.valid && (tok_in.wr == OP_WRITE)
               && (tok_in.wr_layer == 1'(LAYER_ID)) && (tok_in.wr_index == 5'(FLAG_ID));

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.wr == OP_COMPOSE && en_in[CELL_ID])
        begin
            tok_next.color = blend_over(pal_reg, tok_in.color);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tok_in.valid;
            if (hit)
            begin
                pal_reg <= tok_in.wr_color;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
            en_reg  <= en_in;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

    assign en_out = en_reg;

endmodule

@@ hdl/flag_layer_alpha_compositor.sv @@
// ----------------------------------------------------------------------------
// flag_layer_alpha_compositor
// Composites one ARGB pixel from per-layer flag words over a flag palette.
// ----------------------------------------------------------------------------
// The block is a chain of LAYERS*FLAGS_PER_LAYER cells (two layers at most),
// one per palette entry. A request enters the chain at one per clock while
// the chain is not held and passes through one register per cell; each
// cell blends its own palette colour over the passing pixel when that flag is
// shown. Palette writes travel the same chain, so they stay in order with
// pixels. While a finished pixel is not taken the whole chain holds. The
// palette is zero after reset. Registers: 0x0/0x4 visible masks of layer 0/1,
// 0x8/0xC flag counts of layer 0/1.
// ----------------------------------------------------------------------------
module flag_layer_alpha_compositor
    import flac_pkg::*;
#(
    parameter int LAYERS          = 2,
    parameter int FLAGS_PER_LAYER = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    flac_in_if.sink             pix_in,
    flac_out_if.source          pix_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int NL = (LAYERS < FIELD_LAYERS) ? LAYERS : FIELD_LAYERS;
    localparam int NC = NL * FLAGS_PER_LAYER;
    localparam logic [6:0] FPL_LIM = 7'(FLAGS_PER_LAYER);

    logic [31:0]    mask0_reg;
    logic [31:0]    mask1_reg;
    logic [5:0]     cnt0_reg;
    logic [5:0]     cnt1_reg;
    logic           cfg_wr;
    flac_reg_t      cfg_sel;

    flac_tok_t      tok [NC+1];
    logic [NC-1:0]  en  [NC+1];
    logic           adv;
    logic           out_pend;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = flac_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask0_reg <= '0;
            mask1_reg <= '0;
            cnt0_reg  <= '0;
            cnt1_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_MASK0: mask0_reg <= pwdata;
                REG_MASK1: mask1_reg <= pwdata;
                REG_CNT0:  cnt0_reg  <= pwdata[5:0];
                REG_CNT1:  cnt1_reg  <= pwdata[5:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_MASK0: prdata = mask0_reg;
            REG_MASK1: prdata = mask1_reg;
            REG_CNT0:  prdata = {26'd0, cnt0_reg};
            REG_CNT1:  prdata = {26'd0, cnt1_reg};
            default:   prdata = '0;
        endcase
    end

    // chain entry
    assign out_pend     = tok[NC].valid && (tok[NC].wr == OP_COMPOSE);
    assign adv          = !out_pend || pix_out.ready;
    assign pix_in.ready = adv;

    always_comb
    begin
        tok[0].valid    = pix_in.valid;
        tok[0].wr       = pix_in.operation;
        tok[0].wr_layer = pix_in.palette_layer;
        tok[0].wr_index = pix_in.palette_index;
        tok[0].wr_color = pix_in.palette_color;
        tok[0].color    = '0;
    end

    for (genvar l = 0; l < NL; l++)
    begin : g_layer
        logic [31:0] word;
        logic [5:0]  cnt;
        logic [6:0]  rnd;
        logic [6:0]  lim;

        if (l == 0)
        begin : g_l0
            assign word = pix_in.layer0_flags & mask0_reg;
            assign cnt  = cnt0_reg;
        end
        else
        begin : g_l1
            assign word = pix_in.layer1_flags & mask1_reg;
            assign cnt  = cnt1_reg;
        end

        assign rnd = ({1'b0, cnt} + 7'd3) & 7'h7C;
        assign lim = (rnd > FPL_LIM) ? FPL_LIM : rnd;

        for (genvar f = 0; f < FLAGS_PER_LAYER; f++)
        begin : g_flag
            assign en[0][l*FLAGS_PER_LAYER + f] = word[f] && (7'(f) < lim);
        end
    end

    // cell chain
    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        flac_cell #(
            .NC       (NC),
            .CELL_ID  (i),
            .LAYER_ID (i / FLAGS_PER_LAYER),
            .FLAG_ID  (i % FLAGS_PER_LAYER)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (tok[i]),
            .en_in   (en[i]),
            .tok_out (tok[i+1]),
            .en_out  (en[i+1])
        );
    end

    assign pix_out.valid      = out_pend;
    assign pix_out.pixel_argb = tok[NC].color;

endmodule
